>>> rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PAD       = 8'h3d;   // '='
    localparam logic [7:0] CHAR_PLUS      = 8'h2b;   // '+'
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;   // '/'
    localparam logic [7:0] NOT_IN_ALPHA   = 8'hff;
    localparam logic [1:0] FULL_GROUP_CNT = 2'd3;

    // One decoded step: up to three results to be sent out in order.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nres;
        logic            has_bytes;
        logic            done;
        logic            err;
    } job_t;

    typedef struct packed {
        job_t head;
        logic empty;
    } q_head_t;

    // Returns {bad, value}; a character outside the alphabet gives value 255.
    function automatic logic [8:0] sym_decode(input logic [7:0] ch);
        logic [8:0] res;
        res = {1'b1, NOT_IN_ALPHA};
        if (ch >= "A" && ch <= "Z") begin
            res = {1'b0, ch - 8'd65};
        end else if (ch >= "a" && ch <= "z") begin
            res = {1'b0, ch - 8'd71};
        end else if (ch >= "0" && ch <= "9") begin
            res = {1'b0, ch + 8'd4};
        end else if (ch == CHAR_PLUS) begin
            res = {1'b0, 8'd62};
        end else if (ch == CHAR_SLASH) begin
            res = {1'b0, 8'd63};
        end
        return res;
    endfunction

    // Three bytes of a group; each sum wraps to eight bits.
    function automatic logic [2:0][7:0] group_bytes(input logic [7:0] v0,
                                                    input logic [7:0] v1,
                                                    input logic [7:0] v2,
                                                    input logic [7:0] v3);
        logic [2:0][7:0] b;
        b[0] = {v0[5:0], 2'b00} + {6'b0, v1[5:4]};
        b[1] = {v1[3:0], 4'b0000} + {4'b0, v2[5:2]};
        b[2] = {v2[1:0], 6'b000000} + v3;
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64d_front.sv
`default_nettype none

module b64d_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic [7:0]    char_in,
    input  wire logic          end_of_text,
    output b64d_pkg::job_t     job,
    output logic               push
);
    import b64d_pkg::*;

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            pad_reg, pad_next;
    logic            err_reg, err_next;
    logic [8:0]      dec;
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic [7:0]      v2;

    always_comb begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        nbytes    = 2'd0;
        bytes     = '0;
        v2        = NOT_IN_ALPHA;
        dec       = sym_decode(char_in);

        if (!pad_reg && char_in == CHAR_PAD) begin
            pad_next = 1'b1;
        end
        if (!pad_next) begin
            if (dec[8]) begin
                err_next = 1'b1;
            end
            if (cnt_reg == FULL_GROUP_CNT) begin
                bytes    = group_bytes(held_reg[0], held_reg[1], held_reg[2], dec[7:0]);
                nbytes   = 2'd3;
                cnt_next = 2'd0;
            end else begin
                held_next[cnt_reg] = dec[7:0];
                cnt_next           = cnt_reg + 2'd1;
            end
        end

        // At the end of the text a partial group of two or three values is flushed.
        if (end_of_text && nbytes == 2'd0 && cnt_next >= 2'd2) begin
            if (cnt_next == FULL_GROUP_CNT) begin
                v2 = held_next[2];
            end
            bytes  = group_bytes(held_next[0], held_next[1], v2, NOT_IN_ALPHA);
            nbytes = cnt_next - 2'd1;
        end

        job.bytes     = bytes;
        job.has_bytes = (nbytes != 2'd0);
        job.nres      = (nbytes != 2'd0) ? nbytes : 2'd1;
        job.done      = end_of_text;
        job.err       = err_next;
        push          = in_fire && (nbytes != 2'd0 || end_of_text);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            pad_reg <= 1'b0;
            err_reg <= 1'b0;
        end else if (in_fire) begin
            if (end_of_text) begin
                cnt_reg <= 2'd0;
                pad_reg <= 1'b0;
                err_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_next;
                pad_reg <= pad_next;
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64d_queue.sv
`default_nettype none

module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire b64d_pkg::job_t wr_job,
    input  wire logic          pop,
    output b64d_pkg::q_head_t  q_head,
    output logic               full
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full         = (cnt_reg == CNT_W'(DEPTH));
    assign q_head.empty = (cnt_reg == '0);
    assign q_head.head  = mem[rd_ptr_reg];
    assign do_push      = push && !full;
    assign do_pop       = pop && !q_head.empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64d_back.sv
`default_nettype none

module b64d_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire b64d_pkg::q_head_t q_head,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         data_byte,
    output logic               byte_valid,
    output logic               stream_done,
    output logic               bad_symbol
);
    import b64d_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       bval_reg, done_reg, bad_reg;
    logic       load, emit, final_res;

    assign load      = !out_valid_reg || m_tready;
    assign emit      = load && !q_head.empty;
    assign final_res = (idx_reg == q_head.head.nres - 2'd1);
    assign pop       = emit && final_res;

    assign m_tvalid    = out_valid_reg;
    assign data_byte   = byte_reg;
    assign byte_valid  = bval_reg;
    assign stream_done = done_reg;
    assign bad_symbol  = bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            if (load) begin
                out_valid_reg <= !q_head.empty;
            end
            if (emit) begin
                idx_reg <= final_res ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= q_head.head.has_bytes ? q_head.head.bytes[idx_reg] : 8'd0;
            bval_reg <= q_head.head.has_bytes;
            done_reg <= q_head.head.done && final_res;
            bad_reg  <= q_head.head.err;
        end
    end

endmodule

`default_nettype wire

>>> rtl/base64_stream_decoder_top.sv
// Base64 stream decoder (standard alphabet A-Z a-z 0-9 + /).
// Input channel s_*: one ASCII character per request in s_tdata[7:0], with
// s_tlast on the final character of the text. Result channel m_*: one decoded
// byte per request in m_tdata[7:0]; m_tuser[0] says the byte is valid,
// m_tuser[1] reports that a character outside the alphabet was seen in this
// text, and m_tlast marks the final result of the text.
// Every fourth character yields three results; the final character always
// yields at least one result (with the valid flag low if no byte remains).
// An '=' ends decoding for the rest of the text.
// Each decoded group is written into the queue when its character is accepted
// and its results are later loaded from the queue head into the output
// register; further results follow one per cycle while the receiver is ready.
// Throughput: one character per cycle, and one result per cycle while the
// receiver is ready; a queue of QUEUE_DEPTH decoded groups lies between the
// classifier and output register; s_tready drops only when that queue is full.
// When the receiver stalls, the output register holds its request and the
// queue fills; once it is full s_tready stays low until a group is sent out.
// Reset (aresetn low, synchronous) empties the queue and output register and
// starts a fresh text.
`default_nettype none

module base64_stream_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_byte
    output logic [1:0]       m_tuser,   // [0] byte_valid, [1] bad_symbol
    output logic             m_tlast    // stream_done
);
    import b64d_pkg::*;

    job_t    job;
    q_head_t q_head;
    logic    push, pop, full, in_fire;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .char_in     (s_tdata),
        .end_of_text (s_tlast),
        .job         (job),
        .push        (push)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (job),
        .pop     (pop),
        .q_head  (q_head),
        .full    (full)
    );

    b64d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .data_byte   (m_tdata),
        .byte_valid  (m_tuser[0]),
        .stream_done (m_tlast),
        .bad_symbol  (m_tuser[1])
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int LIVE_CHARS       = 310;
    localparam int PAUSE_AT         = 180;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 5000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       bad;
    } dec_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    base64_stream_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    string code_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    char_req_t char_q[$];
    dec_byte_t decoded_q[$];

    // Decoder state as the predictor sees it.
    logic [7:0] held_vals [0:2] = '{8'h00, 8'h00, 8'h00};
    logic [1:0] held_cnt = 2'd0;
    logic       pad_seen = 1'b0;
    logic       err_seen = 1'b0;

    int  n_live     = 0;
    bit  gen_padded = 1'b0;
    int  n_offered  = 0;
    int  n_results  = 0;
    int  n_errors   = 0;
    int  send_gap   = 0;
    int  send_calm  = 0;
    int  recv_gap   = 0;
    int  recv_calm  = 0;
    int  idle_cycles = 0;
    logic long_hold = 1'b0;
    char_req_t next_req;
    dec_byte_t want;

    function automatic logic [2:0][7:0] split_group(input logic [7:0] v0, input logic [7:0] v1,
                                                    input logic [7:0] v2, input logic [7:0] v3);
        logic [2:0][7:0] b;
        b[0] = (v0 << 2) + ((v1 & 8'h30) >> 4);
        b[1] = ((v1 & 8'h0f) << 4) + ((v2 & 8'h3c) >> 2);
        b[2] = ((v2 & 8'h03) << 6) + v3;
        return b;
    endfunction

    // Works out the results one accepted character causes and queues them.
    task automatic decode_char(input logic [7:0] ch, input logic fin);
        logic [7:0]      v;
        logic            bad;
        logic [2:0][7:0] outb;
        int              nb;
        int              k;
        nb = 0;
        v = NOT_IN_ALPHA;
        bad = 1'b0;
        outb = '0;
        if (!pad_seen && ch == CHAR_PAD) begin
            pad_seen = 1'b1;
        end
        if (!pad_seen) begin
            if (ch >= "A" && ch <= "Z") begin
                v = ch - "A";
            end else if (ch >= "a" && ch <= "z") begin
                v = ch - "a" + 8'd26;
            end else if (ch >= "0" && ch <= "9") begin
                v = ch - "0" + 8'd52;
            end else if (ch == CHAR_PLUS) begin
                v = 8'd62;
            end else if (ch == CHAR_SLASH) begin
                v = 8'd63;
            end else begin
                bad = 1'b1;
            end
            if (bad) begin
                err_seen = 1'b1;
            end
            if (held_cnt == FULL_GROUP_CNT) begin
                outb = split_group(held_vals[0], held_vals[1], held_vals[2], v);
                nb = 3;
                held_cnt = 2'd0;
            end else begin
                held_vals[held_cnt] = v;
                held_cnt = held_cnt + 2'd1;
            end
        end
        // A partial group at the end of the text is flushed with the missing
        // values taken as the out-of-alphabet value.
        if (fin && nb == 0 && held_cnt >= 2'd2) begin
            outb = split_group(held_vals[0], held_vals[1],
                               (held_cnt == FULL_GROUP_CNT) ? held_vals[2] : NOT_IN_ALPHA,
                               NOT_IN_ALPHA);
            nb = int'(held_cnt) - 1;
        end
        for (k = 0; k < nb; k++) begin
            decoded_q.push_back(dec_byte_t'{outb[k], 1'b1, fin && (k == nb - 1), err_seen});
        end
        if (fin) begin
            if (nb == 0) begin
                decoded_q.push_back(dec_byte_t'{8'h00, 1'b0, 1'b1, err_seen});
            end
            held_cnt = 2'd0;
            pad_seen = 1'b0;
            err_seen = 1'b0;
        end
    endtask

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] rand_b64();
        return code_chars[$urandom_range(0, 63)];
    endfunction

    // Characters after an '=' are ignored by the block and do not count.
    task automatic add_char(input logic [7:0] ch, input logic fin);
        char_q.push_back(char_req_t'{ch, fin});
        if (!gen_padded) begin
            n_live++;
        end
        if (ch == CHAR_PAD) begin
            gen_padded = 1'b1;
        end
        if (fin) begin
            gen_padded = 1'b0;
        end
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            add_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic add_stream();
        logic [7:0] txt[$];
        int         kind;
        int         ngrp;
        int         i;
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            ngrp = $urandom_range(1, 12);
            for (i = 0; i < ngrp; i++) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            ngrp = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
            for (i = 0; i < ngrp * 4; i++) begin
                txt.push_back(rand_b64());
            end
            case ($urandom_range(0, 4))
                1: begin
                    txt.push_back(rand_b64());
                    txt.push_back(rand_b64());
                    txt.push_back(CHAR_PAD);
                    txt.push_back(CHAR_PAD);
                end
                2: begin
                    for (i = 0; i < 3; i++) begin
                        txt.push_back(rand_b64());
                    end
                    txt.push_back(CHAR_PAD);
                end
                3, 4: begin
                    ngrp = $urandom_range(1, 3);
                    for (i = 0; i < ngrp; i++) begin
                        txt.push_back(rand_b64());
                    end
                end
                default: begin
                end
            endcase
            // Broken texts: a stray character somewhere, or rubbish at the tail.
            if (kind == 7 && txt.size() > 0) begin
                txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            end
            if (kind == 6) begin
                ngrp = $urandom_range(1, 4);
                for (i = 0; i < ngrp; i++) begin
                    txt.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (txt.size() == 0) begin
                txt.push_back(rand_b64());
            end
        end
        for (i = 0; i < txt.size(); i++) begin
            add_char(txt[i], i == txt.size() - 1);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (long_hold) begin
                    send_gap = 0;
                end
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (n_offered == PAUSE_AT && decoded_q.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (char_q.size() != 0) begin
                    next_req = char_q.pop_front();
                    s_tdata  <= next_req.ch;
                    s_tlast  <= next_req.fin;
                    s_tvalid <= 1'b1;
                    n_offered++;
                    send_gap = long_hold ? 0 : draw_wait(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            long_hold <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("unexpected result: data %02h valid %b bad %b last %b",
                                 m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.data || m_tuser[0] !== want.valid ||
                        m_tuser[1] !== want.bad || m_tlast !== want.done) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("result %0d: expected data %02h valid %b bad %b last %b,",
                                     n_results, want.data, want.valid, want.bad, want.done);
                            $display("    got data %02h valid %b bad %b last %b",
                                     m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                        end
                    end
                end
                n_results++;
                recv_gap = (n_results == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                      : draw_wait(recv_calm);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            // While the long hold lasts the sender offers back to back so the
            // block fills up and stalls its input.
            long_hold <= recv_gap > 20;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        add_text("TWFu");
        add_text("TWE=");
        add_text("TQ==");
        add_text("+/90");
        add_text("za");
        add_text("A");
        add_text("=");
        add_char(8'h00, 1'b0);
        add_char("Q", 1'b0);
        add_char(8'hff, 1'b0);
        add_char("z", 1'b1);
        // Characters after padding are dropped, even ones outside the alphabet.
        add_char("Q", 1'b0);
        add_char(CHAR_PAD, 1'b0);
        add_char(8'h80, 1'b1);
        while (n_live < LIVE_CHARS) begin
            add_stream();
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (char_q.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        while (decoded_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (20) @(negedge aclk);
        if (n_errors == 0 && decoded_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
